// ----- sv/idwh_pkg.sv -----
package idwh_pkg;

   // Field widths fixed by the command and response formats.
   localparam int VAL_W     = 10;
   localparam int CMD_W     = 3;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 1;

   // The hole map is kept as rows of one word; a value splits into row and bit position.
   localparam int WORD_BITS = 32;
   localparam int POS_W     = 5;
   localparam int ROW_BITS  = VAL_W - POS_W;

   localparam int DEFAULT_VALUE_RANGE = 1024;

   // Reset values of the configuration registers.
   localparam logic [VAL_W-1:0] INITIAL_LOWER_RST = 10'd0;
   localparam logic [VAL_W-1:0] INITIAL_UPPER_RST = 10'd1023;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_LOWER = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_UPPER = 1'b1;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd0;
   localparam logic [CMD_W-1:0] CMD_RAISE  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_LOWER  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ASSIGN = 3'd3;
   localparam logic [CMD_W-1:0] CMD_UNDO   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_TEST   = 3'd5;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_UNCHANGED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_CHANGED   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [VAL_W-1:0] value;
      logic [VAL_W-1:0] undo_old_lower;
      logic [VAL_W-1:0] undo_old_upper;
      logic [VAL_W-1:0] undo_removed;
      logic             undo_has_removed;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VAL_W-1:0]    old_lower;
      logic [VAL_W-1:0]    old_upper;
      logic [VAL_W-1:0]    removed_value;
      logic                removed_flag;
      logic [VAL_W-1:0]    lower_now;
      logic [VAL_W-1:0]    upper_now;
      logic                fixed;
      logic                member;
   } rsp_type;

   // Lowest set bit of a word: found flag over the bit position.
   function automatic logic [POS_W:0] find_lowest(input logic [WORD_BITS-1:0] w);
      logic [POS_W:0] r;
      r = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (w[i]) begin
            r = {1'b1, POS_W'(i)};
         end
      end
      return r;
   endfunction

   // Highest set bit of a word: found flag over the bit position.
   function automatic logic [POS_W:0] find_highest(input logic [WORD_BITS-1:0] w);
      logic [POS_W:0] r;
      r = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (w[i]) begin
            r = {1'b1, POS_W'(i)};
         end
      end
      return r;
   endfunction

endpackage

// ----- sv/integer_domain_with_holes.sv -----
// Channel   Ports                              Transfer
// --------  ---------------------------------  --------------------------------------
// request   start, busy, req_data              taken when start is high and busy low
// response  rsp_strobe, rsp_data               one-cycle strobe, cannot be held off
// config    csr_we, csr_index, csr_wdata       written on every edge with csr_we high
//
// After reset the hole map is cleared one row of 32 values per cycle with busy high; the
// bounds load from the configuration registers while the first row is cleared.
// A command is busy while it is evaluated and strobes its response in the cycle after; a
// bound command that must scan, or a remove of a bound, stays busy for each row scanned.
// Undo gives no response and is busy only when it clears a hole; unknown codes are ignored.
// The receiver cannot stall; the single read port of the hole map sets every cycle.
module integer_domain_with_holes
   import idwh_pkg::*;
#(
   parameter int VALUE_RANGE = DEFAULT_VALUE_RANGE
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_strobe,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [VAL_W-1:0]     csr_wdata
);

   localparam int ROWS  = (VALUE_RANGE + WORD_BITS - 1) / WORD_BITS;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_EVAL  = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_UNDO  = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [ROW_W-1:0]     clr_ff, clr_in;
   logic [VAL_W-1:0]     init_lower_ff, init_upper_ff;
   logic [VAL_W-1:0]     lower_ff, upper_ff;
   req_type              req_ff;
   logic [VAL_W-1:0]     cur_ff, cur_in;
   logic                 dir_up_ff, dir_up_in;
   logic [WORD_BITS-1:0] word_v_ff, word_v_in;
   logic                 rsp_strobe_ff;
   rsp_type              rsp_ff;

   // Hole-map memory: one row of holes per word, read data registered.
   logic [WORD_BITS-1:0] hole_mem [ROWS];
   logic [WORD_BITS-1:0] mem_q_ff;
   logic                 mem_we;
   logic [ROW_W-1:0]     mem_wa, mem_ra;
   logic [WORD_BITS-1:0] mem_wd;

   logic                 accept, undo_load;
   logic [ROW_BITS-1:0]  cur_row;
   logic [POS_W-1:0]     cur_pos;
   logic                 row_ok;
   logic                 val_ok;
   logic [WORD_BITS-1:0] word, cur_bit, val_bit;
   logic                 in_dom;
   logic                 scan_up;
   logic [POS_W:0]       low_hit, high_hit;
   logic [VAL_W-1:0]     up_cand, dn_cand;
   logic                 done, rem_flag, member;
   logic [STATUS_W-1:0]  status;
   logic [VAL_W-1:0]     lower_new, upper_new;

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && !busy;
   assign undo_load  = accept && (req_data.cmd == CMD_UNDO);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // The word read last edge belongs to the row of cur_ff; rows past the range hold no holes.
   assign cur_row = cur_ff[VAL_W-1:POS_W];
   assign cur_pos = cur_ff[POS_W-1:0];
   assign row_ok  = int'(cur_row) < ROWS;
   assign word    = row_ok ? mem_q_ff : '0;
   assign cur_bit = WORD_BITS'(1) << cur_pos;
   assign val_bit = WORD_BITS'(1) << req_ff.value[POS_W-1:0];

   // Values at or above the range are never recorded as holes.
   assign val_ok = int'(req_ff.value) < VALUE_RANGE;

   // Membership of the request value; valid while cur_ff still holds that value.
   assign in_dom = (req_ff.value >= lower_ff) && (req_ff.value <= upper_ff) &&
                   !word[cur_pos];

   // One row of the hole scan: nearest non-hole at or beyond the scan position.
   assign scan_up  = (state_ff == S_EVAL) ? (req_ff.cmd == CMD_RAISE) : dir_up_ff;
   assign low_hit  = find_lowest(~word & ({WORD_BITS{1'b1}} << cur_pos));
   assign high_hit = find_highest(~word &
                        ({WORD_BITS{1'b1}} >> (POS_W'(WORD_BITS - 1) - cur_pos)));
   assign up_cand  = {cur_row, low_hit[POS_W-1:0]};
   assign dn_cand  = {cur_row, high_hit[POS_W-1:0]};

   // Next read row follows the next scan position.
   assign mem_ra = ROW_W'(cur_in[VAL_W-1:POS_W]);

   // Command sequencing and memory writes.
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      cur_in    = cur_ff;
      dir_up_in = dir_up_ff;
      word_v_in = word_v_ff;
      mem_we    = 1'b0;
      mem_wa    = ROW_W'(cur_row);
      mem_wd    = '0;
      done      = 1'b0;
      status    = ST_UNCHANGED;
      lower_new = lower_ff;
      upper_new = upper_ff;
      rem_flag  = 1'b0;
      member    = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            clr_in = clr_ff + ROW_W'(1);
            if (clr_ff == ROW_W'(ROWS - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (start) begin
               if (req_data.cmd == CMD_UNDO) begin
                  cur_in = req_data.undo_removed;
                  if (req_data.undo_has_removed &&
                      (int'(req_data.undo_removed) < VALUE_RANGE)) begin
                     state_in = S_UNDO;
                  end
               end else begin
                  cur_in = req_data.value;
                  if (req_data.cmd <= CMD_TEST) begin
                     state_in = S_EVAL;
                  end
               end
            end
         end

         S_EVAL: begin
            state_in = S_IDLE;
            unique case (req_ff.cmd)
               CMD_REMOVE: begin
                  word_v_in = word;
                  if (!in_dom) begin
                     done = 1'b1;
                  end else if (req_ff.value == lower_ff) begin
                     if (lower_ff == upper_ff) begin
                        done   = 1'b1;
                        status = ST_EMPTY;
                     end else begin
                        cur_in    = req_ff.value + VAL_W'(1);
                        dir_up_in = 1'b1;
                        state_in  = S_SCAN;
                     end
                  end else if (req_ff.value == upper_ff) begin
                     cur_in    = req_ff.value - VAL_W'(1);
                     dir_up_in = 1'b0;
                     state_in  = S_SCAN;
                  end else begin
                     done     = 1'b1;
                     status   = ST_CHANGED;
                     rem_flag = 1'b1;
                     mem_we   = val_ok;
                     mem_wd   = word | cur_bit;
                  end
               end
               CMD_RAISE, CMD_LOWER: begin
                  if (scan_up ? (req_ff.value <= lower_ff) : (req_ff.value >= upper_ff)) begin
                     done = 1'b1;
                  end else if (scan_up ? (req_ff.value > upper_ff)
                                       : (req_ff.value < lower_ff)) begin
                     done   = 1'b1;
                     status = ST_EMPTY;
                  end else begin
                     dir_up_in = scan_up;
                     state_in  = S_SCAN;
                  end
               end
               CMD_ASSIGN: begin
                  done = 1'b1;
                  if (lower_ff == upper_ff) begin
                     status = ST_UNCHANGED;
                  end else if (!in_dom) begin
                     status = ST_EMPTY;
                  end else begin
                     status    = ST_CHANGED;
                     lower_new = req_ff.value;
                     upper_new = req_ff.value;
                  end
               end
               CMD_TEST: begin
                  done   = 1'b1;
                  member = in_dom;
               end
               default: begin
                  done = 1'b0;
               end
            endcase
         end

         S_SCAN: begin
            state_in = S_IDLE;
            if (scan_up ? low_hit[POS_W] : high_hit[POS_W]) begin
               // A non-hole in this row ends the scan; it must not pass the other bound.
               done = 1'b1;
               if (scan_up ? (up_cand <= upper_ff) : (dn_cand >= lower_ff)) begin
                  status = ST_CHANGED;
                  if (scan_up) begin
                     lower_new = up_cand;
                  end else begin
                     upper_new = dn_cand;
                  end
                  if (req_ff.cmd == CMD_REMOVE) begin
                     rem_flag = 1'b1;
                     mem_we   = val_ok;
                     mem_wa   = ROW_W'(req_ff.value[VAL_W-1:POS_W]);
                     mem_wd   = word_v_ff | val_bit;
                  end
               end else begin
                  status = ST_EMPTY;
               end
            end else if (scan_up ? (cur_row >= upper_ff[VAL_W-1:POS_W])
                                 : (cur_row <= lower_ff[VAL_W-1:POS_W])) begin
               // Whole row is holes and the next row lies past the other bound.
               done   = 1'b1;
               status = ST_EMPTY;
            end else begin
               state_in = S_SCAN;
               if (scan_up) begin
                  cur_in = {cur_row + ROW_BITS'(1), {POS_W{1'b0}}};
               end else begin
                  cur_in = {cur_row - ROW_BITS'(1), {POS_W{1'b1}}};
               end
            end
         end

         S_UNDO: begin
            mem_we   = 1'b1;
            mem_wd   = word & ~cur_bit;
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hole-map memory ports.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hole_mem[mem_wa] <= mem_wd;
      end
      mem_q_ff <= hole_mem[mem_ra];
   end

   // Control state, configuration registers and bounds.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
         init_lower_ff <= INITIAL_LOWER_RST;
         init_upper_ff <= INITIAL_UPPER_RST;
         lower_ff      <= INITIAL_LOWER_RST;
         upper_ff      <= INITIAL_UPPER_RST;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_strobe_ff <= done;
         if (csr_we) begin
            unique case (csr_index)
               CSR_INITIAL_LOWER: init_lower_ff <= csr_wdata;
               CSR_INITIAL_UPPER: init_upper_ff <= csr_wdata;
               default:           init_lower_ff <= init_lower_ff;
            endcase
         end
         if ((state_ff == S_CLEAR) && (clr_ff == '0)) begin
            lower_ff <= init_lower_ff;
            upper_ff <= init_upper_ff;
         end else if (undo_load) begin
            lower_ff <= req_data.undo_old_lower;
            upper_ff <= req_data.undo_old_upper;
         end else if (done) begin
            lower_ff <= lower_new;
            upper_ff <= upper_new;
         end
      end
   end

   // Request capture, scan position and the response register.
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      cur_ff    <= cur_in;
      dir_up_ff <= dir_up_in;
      word_v_ff <= word_v_in;
      if (done) begin
         rsp_ff.status        <= status;
         rsp_ff.old_lower     <= lower_ff;
         rsp_ff.old_upper     <= upper_ff;
         rsp_ff.removed_value <= rem_flag ? req_ff.value : '0;
         rsp_ff.removed_flag  <= rem_flag;
         rsp_ff.lower_now     <= lower_new;
         rsp_ff.upper_now     <= upper_new;
         rsp_ff.fixed         <= (lower_new == upper_new);
         rsp_ff.member        <= member;
      end
   end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb
   import idwh_pkg::*;
();

   localparam int VALUE_RANGE   = DEFAULT_VALUE_RANGE;
   localparam int VALUE_MAX     = (1 << VAL_W) - 1;
   localparam int REQUEST_COUNT = 650;
   localparam int SETTLE_CYCLES = 40;
   localparam int QUIET_FIRST   = 250;
   localparam int QUIET_LAST    = 400;
   localparam int CYCLE_LIMIT   = 400000;

   typedef enum logic [1:0] {STEP_REQ, STEP_DRAIN, STEP_CSR} step_kind_type;

   typedef struct {
      step_kind_type          kind;
      req_type                req;
      logic [CSR_IDX_W-1:0]   idx;
      logic [VAL_W-1:0]       data;
   } step_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_type              req_data = '0;
   logic                 rsp_strobe;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [VAL_W-1:0]     csr_wdata = '0;

   integer_domain_with_holes #(
      .VALUE_RANGE(VALUE_RANGE)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Predicted domain: bounds, hole bitmap and the configuration copy.
   int               dom_lower;
   int               dom_upper;
   bit               hole_bits [VALUE_RANGE];
   logic [VAL_W-1:0] cfg_lower;
   logic [VAL_W-1:0] cfg_upper;

   step_type pending_steps [$];
   rsp_type  expected_domain_rsp [$];
   int       requests_built;
   int       requests_accepted;
   int       gap_left;
   int       settle_left;
   int       mismatches;
   int       cycle_count;
   step_type head_step;
   rsp_type  predicted_rsp;
   rsp_type  check_rsp;
   logic     csr_we_next;

   function automatic bit is_hole(int v);
      if (v < 0 || v >= VALUE_RANGE) begin
         return 1'b0;
      end
      return hole_bits[v];
   endfunction

   function automatic void set_hole(int v, bit b);
      if (v >= 0 && v < VALUE_RANGE) begin
         hole_bits[v] = b;
      end
   endfunction

   function automatic bit in_domain(int v);
      if (v < dom_lower || v > dom_upper) begin
         return 1'b0;
      end
      return !is_hole(v);
   endfunction

   // Move the lower bound up to v, stepping over holes; fails past the upper bound.
   function automatic logic [STATUS_W-1:0] raise_lower(int v);
      if (v <= dom_lower) begin
         return ST_UNCHANGED;
      end
      while (v <= dom_upper && is_hole(v)) begin
         v++;
      end
      if (v > dom_upper) begin
         return ST_EMPTY;
      end
      dom_lower = v;
      return ST_CHANGED;
   endfunction

   // Move the upper bound down to v, stepping over holes; fails below the lower bound.
   function automatic logic [STATUS_W-1:0] drop_upper(int v);
      if (v >= dom_upper) begin
         return ST_UNCHANGED;
      end
      while (v >= dom_lower && is_hole(v)) begin
         v--;
      end
      if (v < dom_lower) begin
         return ST_EMPTY;
      end
      dom_upper = v;
      return ST_CHANGED;
   endfunction

   function automatic void domain_reset();
      cfg_lower = INITIAL_LOWER_RST;
      cfg_upper = INITIAL_UPPER_RST;
      dom_lower = int'(cfg_lower);
      dom_upper = int'(cfg_upper);
      foreach (hole_bits[i]) begin
         hole_bits[i] = 1'b0;
      end
   endfunction

   // Apply one request to the predicted domain; returns 1 when a response is due.
   function automatic bit apply_domain_request(input req_type r, output rsp_type o);
      int                  v;
      int                  prev_lower;
      int                  prev_upper;
      logic [STATUS_W-1:0] st;
      v = int'(r.value);
      prev_lower = dom_lower;
      prev_upper = dom_upper;
      st = ST_UNCHANGED;
      o = '0;
      case (r.cmd)
         CMD_REMOVE: begin
            if (in_domain(v)) begin
               if (v == dom_lower) begin
                  st = raise_lower(v + 1);
               end else if (v == dom_upper) begin
                  st = drop_upper(v - 1);
               end else begin
                  st = ST_CHANGED;
               end
               if (st != ST_EMPTY) begin
                  set_hole(v, 1'b1);
                  st = ST_CHANGED;
                  o.removed_value = VAL_W'(v);
                  o.removed_flag = 1'b1;
               end
            end
         end
         CMD_RAISE: begin
            st = raise_lower(v);
         end
         CMD_LOWER: begin
            st = drop_upper(v);
         end
         CMD_ASSIGN: begin
            if (dom_lower == dom_upper) begin
               st = ST_UNCHANGED;
            end else if (!in_domain(v)) begin
               st = ST_EMPTY;
            end else begin
               dom_lower = v;
               dom_upper = v;
               st = ST_CHANGED;
            end
         end
         CMD_UNDO: begin
            if (r.undo_has_removed) begin
               set_hole(int'(r.undo_removed), 1'b0);
            end
            dom_lower = int'(r.undo_old_lower);
            dom_upper = int'(r.undo_old_upper);
            return 1'b0;
         end
         CMD_TEST: begin
            o.member = in_domain(v);
         end
         default: begin
            return 1'b0;
         end
      endcase
      o.status = st;
      o.old_lower = VAL_W'(prev_lower);
      o.old_upper = VAL_W'(prev_upper);
      o.lower_now = VAL_W'(dom_lower);
      o.upper_now = VAL_W'(dom_upper);
      o.fixed = (dom_lower == dom_upper);
      return 1'b1;
   endfunction

   // Random pause after a request, except inside the quiet stretch.
   function automatic bit take_gap();
      if (requests_accepted >= QUIET_FIRST && requests_accepted < QUIET_LAST) begin
         return 1'b0;
      end
      if ($urandom_range(0, 99) < 15) begin
         gap_left = $urandom_range(1, 6);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Request driver: holds start until the block takes the request.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         csr_we <= 1'b0;
         gap_left = 0;
         settle_left = SETTLE_CYCLES;
         requests_accepted = 0;
         domain_reset();
      end else if (start) begin
         if (!busy) begin
            if (apply_domain_request(req_data, predicted_rsp)) begin
               expected_domain_rsp.push_back(predicted_rsp);
            end
            requests_accepted++;
            if (pending_steps.size() != 0 && pending_steps[0].kind == STEP_REQ && !take_gap())
            begin
               head_step = pending_steps.pop_front();
               req_data <= head_step.req;
            end else begin
               start <= 1'b0;
            end
         end
      end else begin
         csr_we_next = 1'b0;
         // A write seen at this edge lands in the configuration copy.
         if (csr_we) begin
            if (csr_index == CSR_INITIAL_LOWER) begin
               cfg_lower = csr_wdata;
            end else begin
               cfg_upper = csr_wdata;
            end
         end
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_steps.size() != 0) begin
            head_step = pending_steps[0];
            case (head_step.kind)
               STEP_REQ: begin
                  start <= 1'b1;
                  req_data <= head_step.req;
                  void'(pending_steps.pop_front());
               end
               STEP_DRAIN: begin
                  // Wait for every response, then let the block settle.
                  if (expected_domain_rsp.size() != 0 || busy) begin
                     settle_left = SETTLE_CYCLES;
                  end else if (settle_left > 0) begin
                     settle_left--;
                  end else begin
                     settle_left = SETTLE_CYCLES;
                     void'(pending_steps.pop_front());
                  end
               end
               default: begin
                  csr_we_next = 1'b1;
                  csr_index <= head_step.idx;
                  csr_wdata <= head_step.data;
                  void'(pending_steps.pop_front());
               end
            endcase
         end
         csr_we <= csr_we_next;
      end
   end

   function automatic void check_field(string fname, logic [VAL_W-1:0] want,
                                       logic [VAL_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", fname, want, got);
         mismatches++;
      end
   endfunction

   // Response monitor: every strobe is matched against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_domain_rsp.size() == 0) begin
            $error("response with no request outstanding");
            mismatches++;
         end else begin
            check_rsp = expected_domain_rsp.pop_front();
            check_field("status", VAL_W'(check_rsp.status), VAL_W'(rsp_data.status));
            check_field("old_lower", check_rsp.old_lower, rsp_data.old_lower);
            check_field("old_upper", check_rsp.old_upper, rsp_data.old_upper);
            check_field("removed_value", check_rsp.removed_value, rsp_data.removed_value);
            check_field("removed_flag", VAL_W'(check_rsp.removed_flag),
                        VAL_W'(rsp_data.removed_flag));
            check_field("lower_now", check_rsp.lower_now, rsp_data.lower_now);
            check_field("upper_now", check_rsp.upper_now, rsp_data.upper_now);
            check_field("fixed", VAL_W'(check_rsp.fixed), VAL_W'(rsp_data.fixed));
            check_field("member", VAL_W'(check_rsp.member), VAL_W'(rsp_data.member));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("integer_domain_with_holes verification failed");
         $finish;
      end
   end

   // Queue one request; the undo fields of other commands carry random noise.
   function automatic void push_req(logic [CMD_W-1:0] cmd, int value);
      step_type s;
      s.kind = STEP_REQ;
      s.idx = '0;
      s.data = '0;
      s.req.cmd = cmd;
      s.req.value = VAL_W'(value);
      s.req.undo_old_lower = VAL_W'($urandom);
      s.req.undo_old_upper = VAL_W'($urandom);
      s.req.undo_removed = VAL_W'($urandom);
      s.req.undo_has_removed = 1'($urandom_range(0, 1));
      pending_steps.push_back(s);
      if (cmd <= CMD_TEST) begin
         requests_built++;
      end
   endfunction

   function automatic void push_undo(int lo, int hi, int hole, bit has_hole);
      step_type s;
      s.kind = STEP_REQ;
      s.idx = '0;
      s.data = '0;
      s.req.cmd = CMD_UNDO;
      s.req.value = VAL_W'($urandom);
      s.req.undo_old_lower = VAL_W'(lo);
      s.req.undo_old_upper = VAL_W'(hi);
      s.req.undo_removed = VAL_W'(hole);
      s.req.undo_has_removed = has_hole;
      pending_steps.push_back(s);
      requests_built++;
   endfunction

   function automatic void push_drain();
      step_type s;
      s.kind = STEP_DRAIN;
      s.req = '0;
      s.idx = '0;
      s.data = '0;
      pending_steps.push_back(s);
   endfunction

   function automatic void push_csr(logic [CSR_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
      step_type s;
      s.kind = STEP_CSR;
      s.req = '0;
      s.idx = idx;
      s.data = data;
      pending_steps.push_back(s);
   endfunction

   // Mostly values in or just around the window, sometimes anywhere.
   function automatic int pick_value(int lo, int hi);
      int a;
      int b;
      a = ((lo < hi) ? lo : hi) - 2;
      b = ((lo < hi) ? hi : lo) + 2;
      if (a < 0) begin
         a = 0;
      end
      if (b > VALUE_MAX) begin
         b = VALUE_MAX;
      end
      if ($urandom_range(0, 4) == 0) begin
         return int'($urandom_range(0, VALUE_MAX));
      end
      return int'($urandom_range(a, b));
   endfunction

   initial begin
      int w_lo;
      int w_hi;
      int sel;
      int run_start;
      int run_end;
      int next_cfg_at;
      step_type s;

      requests_built = 0;
      mismatches = 0;
      cycle_count = 0;

      // Configuration extremes; they only matter at a reset, so the domain keeps its bounds.
      push_drain();
      push_csr(CSR_INITIAL_LOWER, VAL_W'(VALUE_MAX));
      push_csr(CSR_INITIAL_UPPER, '0);

      // Directed: bound removal, hole skipping, empty outcomes, fixed variable,
      // crossed bounds and ignored command codes.
      push_req(CMD_TEST, 0);
      push_req(CMD_TEST, VALUE_MAX);
      push_req(CMD_REMOVE, 0);
      push_req(CMD_REMOVE, VALUE_MAX);
      push_req(CMD_REMOVE, 500);
      push_req(CMD_REMOVE, 500);
      push_req(CMD_REMOVE, 0);
      push_req(CMD_REMOVE, 501);
      push_req(CMD_REMOVE, 502);
      push_req(CMD_RAISE, 500);
      push_req(CMD_RAISE, 100);
      push_req(CMD_LOWER, 499);
      push_req(CMD_LOWER, VALUE_MAX);
      push_undo(0, VALUE_MAX, 500, 1'b1);
      push_req(CMD_LOWER, 502);
      push_req(CMD_ASSIGN, 501);
      push_req(CMD_ASSIGN, 300);
      push_req(CMD_ASSIGN, 7);
      push_req(CMD_REMOVE, 300);
      push_req(CMD_TEST, 300);
      push_undo(VALUE_MAX, 0, VALUE_MAX, 1'b1);
      push_req(CMD_TEST, 500);
      push_req(CMD_RAISE, VALUE_MAX);
      push_req(CMD_LOWER, 0);
      s.kind = STEP_REQ;
      s.idx = '0;
      s.data = '0;
      s.req = '1;
      pending_steps.push_back(s);
      s.req = '0;
      s.req.cmd = 3'd6;
      pending_steps.push_back(s);
      push_undo(0, VALUE_MAX, 0, 1'b0);

      push_drain();
      push_csr(CSR_INITIAL_LOWER, INITIAL_LOWER_RST);
      push_csr(CSR_INITIAL_UPPER, INITIAL_UPPER_RST);

      // Random: solver-like phases with random content, some noise.
      next_cfg_at = 220;
      while (requests_built < REQUEST_COUNT) begin
         if (requests_built >= next_cfg_at) begin
            push_drain();
            push_csr(CSR_INITIAL_LOWER, VAL_W'($urandom));
            push_csr(CSR_INITIAL_UPPER, VAL_W'($urandom));
            next_cfg_at += 220;
         end
         sel = $urandom_range(0, 9);
         if (sel == 0) begin
            // Noise, unknown command codes included.
            push_req(CMD_W'($urandom_range(0, 7)), $urandom_range(0, VALUE_MAX));
         end else if (sel <= 2) begin
            // A run of holes, a bound pushed into it, then backtracking over it.
            w_lo = $urandom_range(0, 900);
            w_hi = w_lo + $urandom_range(40, 120);
            if (w_hi > VALUE_MAX) begin
               w_hi = VALUE_MAX;
            end
            push_undo(w_lo, w_hi, 0, 1'b0);
            run_start = w_lo + $urandom_range(0, 20);
            run_end = run_start + $urandom_range(4, 40);
            if (run_end > w_hi) begin
               run_end = w_hi;
            end
            for (int v = run_start; v <= run_end; v++) begin
               push_req(CMD_REMOVE, v);
            end
            case ($urandom_range(0, 2))
               0: begin
                  push_req(CMD_RAISE, run_start);
               end
               1: begin
                  push_req(CMD_LOWER, run_end);
               end
               default: begin
                  push_req(CMD_ASSIGN, pick_value(run_start, run_end));
               end
            endcase
            push_req(CMD_TEST, pick_value(w_lo, w_hi));
            for (int v = run_end; v >= run_start; v--) begin
               push_undo(w_lo, w_hi, v, 1'b1);
            end
         end else begin
            // A window of mostly small size, then a burst of commands inside it.
            w_lo = $urandom_range(0, VALUE_MAX);
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
               w_lo = 0;
               w_hi = VALUE_MAX;
            end else if (sel == 1) begin
               w_hi = $urandom_range(0, VALUE_MAX);
            end else begin
               w_hi = w_lo + $urandom_range(0, 63);
               if (w_hi > VALUE_MAX) begin
                  w_hi = VALUE_MAX;
               end
            end
            push_undo(w_lo, w_hi, pick_value(w_lo, w_hi), 1'($urandom_range(0, 1)));
            repeat ($urandom_range(3, 10)) begin
               sel = $urandom_range(0, 19);
               if (sel < 6) begin
                  push_req(CMD_REMOVE, pick_value(w_lo, w_hi));
               end else if (sel < 9) begin
                  push_req(CMD_RAISE, pick_value(w_lo, w_hi));
               end else if (sel < 12) begin
                  push_req(CMD_LOWER, pick_value(w_lo, w_hi));
               end else if (sel < 14) begin
                  push_req(CMD_ASSIGN, pick_value(w_lo, w_hi));
               end else if (sel < 18) begin
                  push_req(CMD_TEST, pick_value(w_lo, w_hi));
               end else begin
                  push_undo(w_lo, w_hi, pick_value(w_lo, w_hi), 1'($urandom_range(0, 1)));
               end
            end
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Wait for the last request, its response and any trailing activity.
      while (pending_steps.size() != 0 || start) begin
         @(posedge clock);
      end
      while (expected_domain_rsp.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_domain_rsp.size() == 0) begin
         $display("integer_domain_with_holes verification clean");
      end else begin
         $display("integer_domain_with_holes verification failed");
      end
      $finish;
   end

endmodule
